// ----- rtl/core/lmr_pkg.sv -----
// ----------------------------------------------------------------------------
// lmr_pkg: shared types and constants of the line midpoint raster unit
// Coordinate, color and decision types, and the command and status groups
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lmr_pkg;

   localparam int COORD_BITS = 6;
   localparam int COLOR_BITS = 24;
   localparam int DEC_BITS   = COORD_BITS + 4;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic [COLOR_BITS-1:0]      color_type;
   typedef logic signed [DEC_BITS-1:0] dec_type;

   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } stat_type;

   function automatic dec_type to_dec(coord_type c);
      return dec_type'({{(DEC_BITS-COORD_BITS){1'b0}}, c});
   endfunction

endpackage

// ----- rtl/core/lmr_req_if.sv -----
// ----------------------------------------------------------------------------
// lmr_req_if: segment request channel
// Valid/ready channel carrying two endpoints and a color.
// ----------------------------------------------------------------------------
interface lmr_req_if;
   logic                valid;
   logic                ready;
   lmr_pkg::coord_type  x_start;
   lmr_pkg::coord_type  y_start;
   lmr_pkg::coord_type  x_end;
   lmr_pkg::coord_type  y_end;
   lmr_pkg::color_type  line_color;

   modport source (output valid, x_start, y_start, x_end, y_end, line_color, input ready);
   modport sink   (input valid, x_start, y_start, x_end, y_end, line_color, output ready);
endinterface

// ----- rtl/core/lmr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lmr_rsp_if: pixel response channel
// Valid/ready channel carrying one pixel with its color and last flag.
// ----------------------------------------------------------------------------
interface lmr_rsp_if;
   logic                valid;
   logic                ready;
   lmr_pkg::coord_type  pixel_x;
   lmr_pkg::coord_type  pixel_y;
   lmr_pkg::color_type  pixel_color;
   logic                last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// ----- rtl/core/lmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lmr_ctrl: walk sequencer
// Accepts a request while idle, then steps the datapath one pixel per cycle
// whenever the output register is free, until the last pixel is issued.
// ----------------------------------------------------------------------------
module lmr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lmr_pkg::stat_type stat,
   output lmr_pkg::cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff;
   logic state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign cmd.load  = req_valid && req_ready;
   assign cmd.emit  = (state_ff == ST_WALK) && stat.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (cmd.emit && stat.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/core/lmr_datapath.sv -----
// ----------------------------------------------------------------------------
// lmr_datapath: midpoint walk datapath
// Sets up the walk from a request, advances the current pixel and decision
// value per step, and holds the issued pixel in the output register.
// ----------------------------------------------------------------------------
module lmr_datapath (
   input  logic               clock,
   input  logic               reset,
   input  lmr_pkg::cmd_type   cmd,
   output lmr_pkg::stat_type  stat,
   input  lmr_pkg::coord_type x_start,
   input  lmr_pkg::coord_type y_start,
   input  lmr_pkg::coord_type x_end,
   input  lmr_pkg::coord_type y_end,
   input  lmr_pkg::color_type line_color,
   lmr_rsp_if.source          rsp
);

   lmr_pkg::coord_type cur_x_ff, cur_x_in;
   lmr_pkg::coord_type cur_y_ff, cur_y_in;
   lmr_pkg::dec_type   dec_ff, dec_in;
   lmr_pkg::coord_type major_end_ff, major_end_in;
   lmr_pkg::dec_type   diag_ff, diag_in;
   lmr_pkg::dec_type   straight_ff, straight_in;
   logic               steep_ff, steep_in;
   logic               minor_neg_ff, minor_neg_in;
   lmr_pkg::color_type color_ff, color_in;

   lmr_pkg::coord_type out_x_ff;
   lmr_pkg::coord_type out_y_ff;
   lmr_pkg::color_type out_color_ff;
   logic               out_last_ff;
   logic               out_valid_ff, out_valid_in;

   lmr_pkg::coord_type adx, ady, sx, sy, ex, ey, cur_major;
   lmr_pkg::dec_type   adx_d, ady_d, adx2, ady2;
   logic               steep_new, swap, step_minor;

   always_comb begin
      adx       = (x_start >= x_end) ? x_start - x_end : x_end - x_start;
      ady       = (y_start >= y_end) ? y_start - y_end : y_end - y_start;
      adx_d     = lmr_pkg::to_dec(adx);
      ady_d     = lmr_pkg::to_dec(ady);
      adx2      = adx_d <<< 1;
      ady2      = ady_d <<< 1;
      steep_new = adx < ady;
      swap      = steep_new ? (y_end < y_start) : (x_end < x_start);
      sx        = swap ? x_end : x_start;
      sy        = swap ? y_end : y_start;
      ex        = swap ? x_start : x_end;
      ey        = swap ? y_start : y_end;
   end

   assign cur_major     = steep_ff ? cur_y_ff : cur_x_ff;
   assign stat.last     = cur_major >= major_end_ff;
   assign stat.out_free = !out_valid_ff || rsp.ready;

   // track the unmirrored decision; mirroring only flips the minor direction
   assign step_minor = steep_ff ? !dec_ff[lmr_pkg::DEC_BITS-1]
                                : (dec_ff[lmr_pkg::DEC_BITS-1] || dec_ff == '0);

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      dec_in       = dec_ff;
      major_end_in = major_end_ff;
      diag_in      = diag_ff;
      straight_in  = straight_ff;
      steep_in     = steep_ff;
      minor_neg_in = minor_neg_ff;
      color_in     = color_ff;
      if (cmd.load) begin
         cur_x_in     = sx;
         cur_y_in     = sy;
         steep_in     = steep_new;
         minor_neg_in = steep_new ? (ex < sx) : (ey < sy);
         major_end_in = steep_new ? ey : ex;
         dec_in       = steep_new ? adx2 - ady_d : adx_d - ady2;
         diag_in      = adx2 - ady2;
         straight_in  = steep_new ? adx2 : -ady2;
         color_in     = line_color;
      end else if (cmd.emit && !stat.last) begin
         dec_in = dec_ff + (step_minor ? diag_ff : straight_ff);
         if (steep_ff) begin
            cur_y_in = cur_y_ff + 1'b1;
            if (step_minor) cur_x_in = minor_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
         end else begin
            cur_x_in = cur_x_ff + 1'b1;
            if (step_minor) cur_y_in = minor_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
         end
      end
   end

   assign out_valid_in = cmd.emit || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         dec_ff       <= '0;
         major_end_ff <= '0;
         diag_ff      <= '0;
         straight_ff  <= '0;
         steep_ff     <= 1'b0;
         minor_neg_ff <= 1'b0;
         color_ff     <= '0;
      end else begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         dec_ff       <= dec_in;
         major_end_ff <= major_end_in;
         diag_ff      <= diag_in;
         straight_ff  <= straight_in;
         steep_ff     <= steep_in;
         minor_neg_ff <= minor_neg_in;
         color_ff     <= color_in;
      end
      if (cmd.emit) begin
         out_x_ff     <= cur_x_ff;
         out_y_ff     <= cur_y_ff;
         out_color_ff <= color_ff;
         out_last_ff  <= stat.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.pixel_x     = out_x_ff;
   assign rsp.pixel_y     = out_y_ff;
   assign rsp.pixel_color = out_color_ff;
   assign rsp.last_pixel  = out_last_ff;

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("pixel issued into a full output register");

   a_no_load_during_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.emit)
      else $error("request loaded while a walk is issuing pixels");

   a_stop_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && stat.last) |=> !cmd.emit)
      else $error("pixel issued after the last pixel of a segment");

   a_major_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !stat.last) |=>
         (cur_major == lmr_pkg::coord_type'($past(cur_major) + 1'b1)))
      else $error("major coordinate did not advance by one");

endmodule

// ----- rtl/core/line_midpoint_raster_unit.sv -----
// ----------------------------------------------------------------------------
// line_midpoint_raster_unit: midpoint line rasterizer for a 64x64 tile
// A request on req carries two endpoints and a 24-bit color. The unit walks
// the segment along its major axis from the endpoint with the lower major
// coordinate and returns one response on rsp per pixel, with last_pixel set
// on the final pixel. Equal endpoints give a single pixel.
// Once a request is accepted, the sequencer enters its walk state and the
// first pixel reaches rsp through the output register. Pixels then follow
// one per cycle while rsp.ready stays high. A segment has n pixels (n up to
// 64); the next request is accepted in the cycle after the last pixel
// enters the output register, while that pixel may still wait on rsp. The
// walk advances one step per cycle through a single decision-value adder;
// the output register decouples it from the receiver.
// When rsp.ready is low the output register holds its pixel and the walk
// pauses; no pixel is lost or repeated.
// Reset clears the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module line_midpoint_raster_unit (
   input  logic      clock,
   input  logic      reset,
   lmr_req_if.sink   req,
   lmr_rsp_if.source rsp
);

   lmr_pkg::cmd_type  cmd;
   lmr_pkg::stat_type stat;

   lmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lmr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .x_start    (req.x_start),
      .y_start    (req.y_start),
      .x_end      (req.x_end),
      .y_end      (req.y_end),
      .line_color (req.line_color),
      .rsp        (rsp)
   );

endmodule
